[rtl/lzw_byte_stream_encoder_macros.svh]
// Assertion macros used by the port checker of the LZW byte-stream encoder.
`ifndef LZW_BYTE_STREAM_ENCODER_MACROS_SVH
`define LZW_BYTE_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define LBSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbse: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define LBSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbse: assertion failed");

`endif

[rtl/lbse_pkg.sv]
// Shared types and constants of the LZW byte-stream encoder.
package lbse_pkg;

  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned CODE_FIELD_W     = 12;
  localparam int unsigned EPOCH_W          = 8;
  localparam int unsigned DICT_ENTRIES_DEF = 4096;
  localparam int unsigned FIRST_PHRASE     = 256;
  localparam int unsigned OUT_FIFO_DEPTH   = 4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_FLUSH
  } lbse_state_e;

  typedef struct packed {
    logic [CODE_FIELD_W-1:0] code;
    logic                    last_code;
  } lbse_out_word_t;

endpackage

[rtl/lbse_if.sv]
// Stream interfaces of the LZW byte-stream encoder: byte input and code output.
interface lbse_in_if import lbse_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface lbse_out_if import lbse_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [CODE_FIELD_W-1:0] code;
  logic                    last_code;

  modport source (output valid, output code, output last_code, input ready);
  modport sink   (input valid, input code, input last_code, output ready);
endinterface

[rtl/lbse_hash_ram.sv]
// Single-port-write, single-port-read synchronous RAM for the phrase hash table.
module lbse_hash_ram import lbse_pkg::*; #(
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DATA_W = 40
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/lbse_out_fifo.sv]
// Small output queue that decouples emitted codes from the downstream handshake.
module lbse_out_fifo import lbse_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lbse_out_word_t push_word_i,
  output logic           room_o,
  lbse_out_if.source     out_o
);

  localparam int unsigned PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  lbse_out_word_t   mem_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  lbse_out_word_t   head;

  assign pop             = out_o.valid && out_o.ready;
  assign head            = mem_q[rd_ptr_q];
  assign out_o.valid     = (cnt_q != '0);
  assign out_o.code      = head.code;
  assign out_o.last_code = head.last_code;
  // Room for the two words one byte can produce.
  assign room_o          = (cnt_q <= CNT_W'(OUT_FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

[rtl/lzw_byte_stream_encoder.sv]
// Top level of the LZW byte-stream encoder: prefix state machine over a hashed phrase table.
//
//   channel     dir  port        words carried
//   ---------   ---  ----------  -------------------------------------------
//   byte in     in   in_chan_i   data_byte[7:0], end_of_message
//   code out    out  out_chan_o  code[11:0], last_code
//
// A byte that opens a message is taken in ST_IDLE with no table read. Any other byte is
// accepted, then its home slot is read, then one more slot per linear probe; the hash
// table is twice the dictionary size, so probe chains stay short. The last byte of a
// message adds ST_FLUSH to flush the prefix. The hash RAM read port is registered.
// After reset, and again after every 255 messages, a clearing pass writes all
// 2**(clog2(DICT_ENTRIES)+1) table entries, one per cycle, with in_chan_i.ready low.
// Input also stalls in ST_PROBE and ST_FLUSH and while the output FIFO lacks two free words.
module lzw_byte_stream_encoder import lbse_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbse_in_if.sink     in_chan_i,
  lbse_out_if.source  out_chan_o
);

  // Code width follows the dictionary size; the hash table has twice as many slots.
  localparam int unsigned CODE_W = $clog2(DICT_ENTRIES);
  localparam int unsigned NFC_W  = CODE_W + 1;
  localparam int unsigned HA_W   = CODE_W + 1;
  localparam int unsigned KEY_W  = CODE_W + BYTE_W;
  // Slot layout: {epoch, prefix code, byte, phrase code}.
  localparam int unsigned ENT_W  = EPOCH_W + KEY_W + CODE_W;

  lbse_state_e       state_q, state_d;
  logic [CODE_W-1:0] prefix_q, prefix_d;
  logic              prefix_valid_q, prefix_valid_d;
  logic [NFC_W-1:0]  next_free_q, next_free_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              eom_q, eom_d;
  logic [HA_W-1:0]   slot_q, slot_d;
  logic [HA_W-1:0]   clr_addr_q, clr_addr_d;

  logic              in_acc;
  logic [HA_W-1:0]   hash_addr;
  logic [HA_W-1:0]   rd_addr;
  logic [ENT_W-1:0]  rd_data;
  logic              wr_en;
  logic [HA_W-1:0]   wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [EPOCH_W-1:0] ent_epoch;
  logic [KEY_W-1:0]  ent_key;
  logic [CODE_W-1:0] ent_code;
  logic              ent_live;
  logic              ent_match;

  logic              fifo_room;
  logic              push;
  lbse_out_word_t    push_word;
  logic [CODE_W+CODE_FIELD_W-1:0] prefix_ext;

  assign in_acc = in_chan_i.valid && in_chan_i.ready;

  // Fold the byte onto the upper prefix bits to spread keys over the table.
  assign hash_addr = {1'b0, prefix_q} ^ {in_chan_i.data_byte, {(HA_W-BYTE_W){1'b0}}};

  // Slot fields; a slot is live only when written in the current epoch.
  assign ent_epoch = rd_data[ENT_W-1 -: EPOCH_W];
  assign ent_key   = rd_data[CODE_W +: KEY_W];
  assign ent_code  = rd_data[CODE_W-1:0];
  assign ent_live  = (ent_epoch == epoch_q);
  assign ent_match = ent_live && (ent_key == {prefix_q, byte_q});

  // Codes are shown in the 12-bit field: zero-extend narrow codes, mask wide ones.
  assign prefix_ext = {{CODE_FIELD_W{1'b0}}, prefix_q};

  always_comb begin
    state_d         = state_q;
    prefix_d        = prefix_q;
    prefix_valid_d  = prefix_valid_q;
    next_free_d     = next_free_q;
    epoch_d         = epoch_q;
    byte_d          = byte_q;
    eom_d           = eom_q;
    slot_d          = slot_q;
    clr_addr_d      = clr_addr_q;
    rd_addr         = slot_q;
    wr_en           = 1'b0;
    wr_addr         = slot_q;
    wr_data         = {epoch_q, prefix_q, byte_q, next_free_q[CODE_W-1:0]};
    push            = 1'b0;
    push_word.code      = prefix_ext[CODE_FIELD_W-1:0];
    push_word.last_code = 1'b0;
    in_chan_i.ready = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the table to epoch zero, one slot per cycle.
        wr_en      = 1'b1;
        wr_addr    = clr_addr_q;
        wr_data    = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_chan_i.ready = fifo_room;
        if (in_acc) begin
          byte_d = in_chan_i.data_byte;
          eom_d  = in_chan_i.end_of_message;
          if (!prefix_valid_q) begin
            // Open a message: the byte itself is the prefix, nothing emitted.
            prefix_d       = {{(CODE_W-BYTE_W){1'b0}}, in_chan_i.data_byte};
            prefix_valid_d = 1'b1;
            state_d        = in_chan_i.end_of_message ? ST_FLUSH : ST_IDLE;
          end else begin
            // Start the lookup of (prefix, byte) at its home slot.
            rd_addr = hash_addr;
            slot_d  = hash_addr;
            state_d = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        priority if (ent_match) begin
          // Known phrase: extend the prefix.
          prefix_d = ent_code;
          state_d  = eom_q ? ST_FLUSH : ST_IDLE;
        end else if (ent_live) begin
          // Slot taken by another phrase: advance to the next slot.
          rd_addr = slot_q + 1'b1;
          slot_d  = slot_q + 1'b1;
        end else begin
          // Free slot: emit the prefix, record the pair unless the dictionary is full.
          push = 1'b1;
          if (next_free_q < NFC_W'(DICT_ENTRIES)) begin
            wr_en       = 1'b1;
            next_free_d = next_free_q + 1'b1;
          end
          prefix_d = {{(CODE_W-BYTE_W){1'b0}}, byte_q};
          state_d  = eom_q ? ST_FLUSH : ST_IDLE;
        end
      end

      ST_FLUSH: begin
        // Flush the prefix as the last word, drop the dictionary by moving the epoch.
        push                = 1'b1;
        push_word.last_code = 1'b1;
        prefix_d            = '0;
        prefix_valid_d      = 1'b0;
        next_free_d         = NFC_W'(FIRST_PHRASE);
        if (epoch_q == '1) begin
          epoch_d    = EPOCH_W'(1);
          clr_addr_d = '0;
          state_d    = ST_CLEAR;
        end else begin
          epoch_d = epoch_q + 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q       <= '0;
      prefix_valid_q <= 1'b0;
      next_free_q    <= NFC_W'(FIRST_PHRASE);
      epoch_q        <= EPOCH_W'(1);
      eom_q          <= 1'b0;
      slot_q         <= '0;
      clr_addr_q     <= '0;
    end else begin
      prefix_q       <= prefix_d;
      prefix_valid_q <= prefix_valid_d;
      next_free_q    <= next_free_d;
      epoch_q        <= epoch_d;
      eom_q          <= eom_d;
      slot_q         <= slot_d;
      clr_addr_q     <= clr_addr_d;
    end
  end

  // Byte payload needs no reset.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  lbse_hash_ram #(
    .ADDR_W (HA_W),
    .DATA_W (ENT_W)
  ) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lbse_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .room_o      (fifo_room),
    .out_o       (out_chan_o)
  );

endmodule

[rtl/lbse_port_checker.sv]
// Port-level checks of the LZW byte-stream encoder, bound to the top level.
`include "lzw_byte_stream_encoder_macros.svh"

module lbse_port_checker import lbse_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_eom_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [CODE_FIELD_W-1:0] out_code_i,
  input logic                    out_last_i
);

  logic                  out_stall;
  logic [CODE_FIELD_W:0] out_word;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_word  = {out_code_i, out_last_i};

  // Hold a stalled output word.
  `LBSE_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `LBSE_ASSERT_NEXT(a_out_word_hold, clk_i, rst_ni, out_stall, $stable(out_word))
  // Taking the last byte of a message drops in_ready, as a flush follows.
  `LBSE_ASSERT_NEXT(a_eom_flush, clk_i, rst_ni, in_valid_i && in_ready_i && in_eom_i, !in_ready_i)
  // An idle, ready block stays ready until it takes a byte.
  `LBSE_ASSERT_NEXT(a_ready_keep, clk_i, rst_ni, in_ready_i && !in_valid_i, in_ready_i)

endmodule

bind lzw_byte_stream_encoder lbse_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .in_eom_i    (in_chan_i.end_of_message),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .out_code_i  (out_chan_o.code),
  .out_last_i  (out_chan_o.last_code)
);
